// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, sampled on the rising clock edge
// and switched off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// ===== rtl/core/ucle_pkg.sv =====
// ----------------------------------------------------------------------------
// ucle_pkg
// Shared types and constants of the console line editor.
// ----------------------------------------------------------------------------
package ucle_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutW    = 48;

  localparam logic [ByteW-1:0] ChBs   = 8'h08;
  localparam logic [ByteW-1:0] ChDel  = 8'h7F;
  localparam logic [ByteW-1:0] ChCsi  = 8'h5B;
  localparam logic [ByteW-1:0] ChEsc  = 8'h1B;
  localparam logic [ByteW-1:0] ChCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChLf   = 8'h0A;
  localparam logic [ByteW-1:0] ChSp   = 8'h20;
  localparam logic [ByteW-1:0] MsgMax = 8'hFF;

  typedef enum logic [KindW-1:0] {
    KIND_RX_BYTE    = 2'd0,
    KIND_TX_READY   = 2'd1,
    KIND_HOST_READ  = 2'd2,
    KIND_HOST_WRITE = 2'd3
  } kind_e;

  // Result fields apart from the two bytes that come out of the rings
  typedef struct packed {
    logic              line_valid;
    logic              host_valid;
    logic              refused;
    logic [ByteW-1:0]  messages;
    logic              transmit_enable;
    logic [LevelW-1:0] receive_level;
    logic [LevelW-1:0] transmit_level;
  } res_t;

endpackage

// ===== rtl/core/ucle_ram.sv =====
// ----------------------------------------------------------------------------
// ucle_ram
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ucle_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [ucle_pkg::ByteW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [ucle_pkg::ByteW-1:0] rdata_o
);

  logic [ucle_pkg::ByteW-1:0] mem [Depth];
  logic [ucle_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ucle_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucle_ctrl
// Ring pointers, edit history, line count and echo write sequencing.
// ----------------------------------------------------------------------------
module ucle_ctrl #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned AddrW      = 6,
  parameter int unsigned CntW       = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  ucle_pkg::kind_e            kind_i,
  input  logic [ucle_pkg::ByteW-1:0] byte_i,
  output logic                       busy_o,
  output ucle_pkg::res_t             res_o,
  // receive ring ports
  output logic                       rx_we_o,
  output logic [AddrW-1:0]           rx_waddr_o,
  output logic [ucle_pkg::ByteW-1:0] rx_wdata_o,
  output logic                       rx_re_o,
  output logic [AddrW-1:0]           rx_raddr_o,
  // transmit ring ports
  output logic                       tx_we_o,
  output logic [AddrW-1:0]           tx_waddr_o,
  output logic [ucle_pkg::ByteW-1:0] tx_wdata_o,
  output logic                       tx_re_o,
  output logic [AddrW-1:0]           tx_raddr_o
);

  localparam int unsigned OffW = CntW + 1;
  localparam int unsigned SumW = CntW + 2;
  localparam logic [CntW-1:0] DepthC = CntW'(RING_DEPTH);
  localparam logic [SumW-1:0] DepthS = SumW'(RING_DEPTH);

  function automatic logic [AddrW-1:0] slot(input logic [AddrW-1:0] head,
                                            input logic [OffW-1:0]  off);
    logic [SumW-1:0] s;
    s = SumW'(head) + SumW'(off);
    if (s >= DepthS) begin
      s = s - DepthS;
    end
    return s[AddrW-1:0];
  endfunction

  logic [AddrW-1:0]           rh_q, rh_d, th_q, th_d, pend_addr_q, pend_addr_d;
  logic [CntW-1:0]            rc_q, rc_d, tc_q, tc_d;
  logic [ucle_pkg::ByteW-1:0] last_q, last_d, sec_q, sec_d, msg_q, msg_d;
  logic [ucle_pkg::ByteW-1:0] pend0_q, pend0_d, pend1_q, pend1_d;
  logic [1:0]                 pend_cnt_q, pend_cnt_d;
  logic                       tie_q, tie_d;
  logic                       lv, hv, refused;
  logic [OffW-1:0]            tc1, tc2;
  logic                       f0, f1, f2, is_erase, pass;

  assign tc1      = OffW'(tc_q) + OffW'(1);
  assign tc2      = OffW'(tc_q) + OffW'(2);
  assign f0       = tc_q < DepthC;
  assign f1       = tc1 < OffW'(RING_DEPTH);
  assign f2       = tc2 < OffW'(RING_DEPTH);
  assign is_erase = (byte_i == ucle_pkg::ChBs) || (byte_i == ucle_pkg::ChDel);
  assign pass     = (last_q != ucle_pkg::ChCsi) && (sec_q != ucle_pkg::ChEsc) &&
                    (byte_i != ucle_pkg::ChEsc) && (byte_i != ucle_pkg::ChCsi);
  assign busy_o   = pend_cnt_q != 2'd0;

  always_comb begin
    rh_d = rh_q;  th_d = th_q;  rc_d = rc_q;  tc_d = tc_q;
    last_d = last_q;  sec_d = sec_q;  msg_d = msg_q;  tie_d = tie_q;
    pend0_d = pend0_q;  pend1_d = pend1_q;
    pend_cnt_d = pend_cnt_q;  pend_addr_d = pend_addr_q;
    lv = 1'b0;  hv = 1'b0;  refused = 1'b0;
    rx_we_o = 1'b0;  rx_waddr_o = slot(rh_q, OffW'(rc_q));  rx_wdata_o = byte_i;
    rx_re_o = 1'b0;  rx_raddr_o = rh_q;
    tx_we_o = 1'b0;  tx_waddr_o = slot(th_q, OffW'(tc_q));  tx_wdata_o = byte_i;
    tx_re_o = 1'b0;  tx_raddr_o = th_q;

    // drain queued echo bytes, one per cycle
    if (busy_o) begin
      tx_we_o     = 1'b1;
      tx_waddr_o  = pend_addr_q;
      tx_wdata_o  = pend0_q;
      pend0_d     = pend1_q;
      pend_cnt_d  = pend_cnt_q - 2'd1;
      pend_addr_d = slot(pend_addr_q, OffW'(1));
    end

    if (fire_i) begin
      case (kind_i)
        ucle_pkg::KIND_RX_BYTE: begin
          if (is_erase) begin
            if (rc_q != '0) begin
              rc_d        = rc_q - CntW'(1);
              tx_we_o     = f0;
              tx_wdata_o  = ucle_pkg::ChBs;
              pend0_d     = ucle_pkg::ChSp;
              pend1_d     = ucle_pkg::ChBs;
              pend_cnt_d  = 2'(f1) + 2'(f2);
              pend_addr_d = slot(th_q, tc1);
              tc_d        = tc_q + CntW'(f0) + CntW'(f1) + CntW'(f2);
              tie_d       = 1'b1;
            end
          end else if (pass) begin
            if (byte_i == ucle_pkg::ChLf && msg_q != ucle_pkg::MsgMax) begin
              msg_d = msg_q + 8'd1;
            end
            if (rc_q < DepthC) begin
              rx_we_o = 1'b1;
              rc_d    = rc_q + CntW'(1);
            end
            if (f0) begin
              tx_we_o = 1'b1;
              tie_d   = 1'b1;
              tc_d    = tc_q + CntW'(1);
              if (byte_i == ucle_pkg::ChCr && f1) begin
                pend0_d     = ucle_pkg::ChLf;
                pend_cnt_d  = 2'd1;
                pend_addr_d = slot(th_q, tc1);
                tc_d        = tc_q + CntW'(2);
              end
            end
          end
          sec_d  = last_q;
          last_d = byte_i;
        end
        ucle_pkg::KIND_TX_READY: begin
          if (tc_q != '0) begin
            tx_re_o = 1'b1;
            lv      = 1'b1;
            th_d    = slot(th_q, OffW'(1));
            tc_d    = tc_q - CntW'(1);
          end else begin
            tie_d = 1'b0;
          end
        end
        ucle_pkg::KIND_HOST_READ: begin
          if (rc_q != '0) begin
            rx_re_o = 1'b1;
            hv      = 1'b1;
            rh_d    = slot(rh_q, OffW'(1));
            rc_d    = rc_q - CntW'(1);
          end else begin
            refused = 1'b1;
          end
        end
        ucle_pkg::KIND_HOST_WRITE: begin
          if (f0) begin
            tx_we_o = 1'b1;
            tie_d   = 1'b1;
            tc_d    = tc_q + CntW'(1);
          end else begin
            refused = 1'b1;
          end
        end
        default: begin
          refused = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_o.line_valid      = lv;
    res_o.host_valid      = hv;
    res_o.refused         = refused;
    res_o.messages        = msg_d;
    res_o.transmit_enable = tie_d;
    res_o.receive_level   = ucle_pkg::LevelW'(rc_d);
    res_o.transmit_level  = ucle_pkg::LevelW'(tc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q       <= '0;
      th_q       <= '0;
      rc_q       <= '0;
      tc_q       <= '0;
      last_q     <= '0;
      sec_q      <= '0;
      msg_q      <= '0;
      tie_q      <= 1'b0;
      pend_cnt_q <= 2'd0;
    end else begin
      rh_q       <= rh_d;
      th_q       <= th_d;
      rc_q       <= rc_d;
      tc_q       <= tc_d;
      last_q     <= last_d;
      sec_q      <= sec_d;
      msg_q      <= msg_d;
      tie_q      <= tie_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q     <= pend0_d;
    pend1_q     <= pend1_d;
    pend_addr_q <= pend_addr_d;
  end

endmodule

// ===== rtl/core/uart_console_line_editor.sv =====
// An event waits in the input register while echo bytes drain or the result
// slot is full, then passes to the result register. Throughput: one event per
// cycle otherwise; an echoed erase writes three bytes, a carriage return two.
// Reset: asynchronous, active low; empties both rings and clears the edit
// history, line count and transmit enable. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// uart_console_line_editor
// Console front end: edits and echoes received line bytes through a receive
// and a transmit ring, feeds the line and serves host reads and writes.
// ----------------------------------------------------------------------------
module uart_console_line_editor #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // event stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,  // [7:0] byte_in
  input  logic [1:0]                s_axis_tuser_i,  // [1:0] kind
  // result stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [0] line_valid, [8:1] line_byte, [9] host_valid, [17:10] host_byte,
  // [18] refused, [26:19] messages, [27] transmit_enable,
  // [34:28] receive_level, [41:35] transmit_level, [47:42] zero
  output logic [ucle_pkg::OutW-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);

  // Input register: hold the event until the edit logic takes it
  logic                       in_valid_q;
  ucle_pkg::kind_e            in_kind_q;
  logic [ucle_pkg::ByteW-1:0] in_byte_q;

  // Result register: the ring bytes sit in the RAM read registers alongside
  logic                       out_valid_q;
  ucle_pkg::res_t             res_q;
  ucle_pkg::res_t             res_d;

  logic busy;
  logic fire;
  logic out_free;

  logic                       rx_we, rx_re, tx_we, tx_re;
  logic [AddrW-1:0]           rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [ucle_pkg::ByteW-1:0] rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  logic [ucle_pkg::ByteW-1:0] line_byte, host_byte;

  // Advance an event when the result slot frees and no echo bytes are queued
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && !busy && out_free;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= ucle_pkg::kind_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
  end

  ucle_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .kind_i     (in_kind_q),
    .byte_i     (in_byte_q),
    .busy_o     (busy),
    .res_o      (res_d),
    .rx_we_o    (rx_we),
    .rx_waddr_o (rx_waddr),
    .rx_wdata_o (rx_wdata),
    .rx_re_o    (rx_re),
    .rx_raddr_o (rx_raddr),
    .tx_we_o    (tx_we),
    .tx_waddr_o (tx_waddr),
    .tx_wdata_o (tx_wdata),
    .tx_re_o    (tx_re),
    .tx_raddr_o (tx_raddr)
  );

  ucle_ram #(
    .Depth (RING_DEPTH),
    .AddrW (AddrW)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  ucle_ram #(
    .Depth (RING_DEPTH),
    .AddrW (AddrW)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Drop stale read data when no byte was popped
  assign line_byte = res_q.line_valid ? tx_rdata : '0;
  assign host_byte = res_q.host_valid ? rx_rdata : '0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0,
                            res_q.transmit_level,
                            res_q.receive_level,
                            res_q.transmit_enable,
                            res_q.messages,
                            res_q.refused,
                            host_byte,
                            res_q.host_valid,
                            line_byte,
                            res_q.line_valid};

endmodule

// ===== rtl/core/ucle_checker.sv =====
// ----------------------------------------------------------------------------
// ucle_checker
// Port-level checks on the console line editor result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucle_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ucle_pkg::OutW-1:0] m_axis_tdata_o
);

  localparam bit LevelWraps = RING_DEPTH > 127;

  logic                        lv, hv, refused, tie;
  logic [ucle_pkg::LevelW-1:0] rl, tl;
  logic                        in_xfer;

  assign lv      = m_axis_tdata_o[0];
  assign hv      = m_axis_tdata_o[9];
  assign refused = m_axis_tdata_o[18];
  assign tie     = m_axis_tdata_o[27];
  assign rl      = m_axis_tdata_o[34:28];
  assign tl      = m_axis_tdata_o[41:35];
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "result changed while stalled")
  `ASSERT_NEVER(a_refused_excl, clk_i, rst_ni, m_axis_tvalid_o && refused && (lv || hv), "refused event also delivered a byte")
  `ASSERT_PROP(a_tx_enable, clk_i, rst_ni, m_axis_tvalid_o |-> (tl == '0 || tie), "transmit ring holds bytes with enable clear")
  `ASSERT_PROP(a_levels, clk_i, rst_ni, m_axis_tvalid_o |-> (LevelWraps || (rl <= ucle_pkg::LevelW'(RING_DEPTH) && tl <= ucle_pkg::LevelW'(RING_DEPTH))), "ring level beyond depth")
  `ASSERT_PROP(a_no_spurious, clk_i, rst_ni, (!m_axis_tvalid_o && !in_xfer && !s_axis_tready_o) |=> !m_axis_tvalid_o || $past(s_axis_tvalid_i), "result without a pending event")

endmodule

bind uart_console_line_editor ucle_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_ucle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/uart_console_line_editor_tb.sv =====
// ----------------------------------------------------------------------------
// uart_console_line_editor_tb
// Streams console events into the line editor and checks every result
// transfer field by field against a cycle-free model of the two byte rings,
// the edit history, the line count and the transmit enable. Covers erase
// echo, the escape filter, ring full and empty cases and count saturation,
// with random stalls on both streams.
// ----------------------------------------------------------------------------
module uart_console_line_editor_tb;
  import ucle_pkg::*;

  localparam int unsigned RingDepth  = 64;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdlePct    = 38;

  typedef struct {
    kind_e           kind;
    logic [ByteW-1:0] data;
  } console_event_t;

  typedef struct packed {
    logic              line_valid;
    logic [ByteW-1:0]  line_byte;
    logic              host_valid;
    logic [ByteW-1:0]  host_byte;
    logic              refused;
    logic [ByteW-1:0]  messages;
    logic              transmit_enable;
    logic [LevelW-1:0] receive_level;
    logic [LevelW-1:0] transmit_level;
  } console_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i = '0;  // [7:0] byte_in
  logic [1:0]        s_axis_tuser_i = '0;  // [1:0] kind
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  // [0] line_valid, [8:1] line_byte, [9] host_valid, [17:10] host_byte,
  // [18] refused, [26:19] messages, [27] transmit_enable,
  // [34:28] receive_level, [41:35] transmit_level
  logic [OutW-1:0]   m_axis_tdata_o;

  uart_console_line_editor #(.RING_DEPTH(RingDepth)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // Events waiting to be offered, and results owed by the block, oldest first
  console_event_t  pending_events[$];
  console_result_t owed_results[$];
  int unsigned     queued = 0;
  int unsigned     errors = 0;

  // Controls shared with the stream processes; written on the falling edge only
  bit          calm = 1'b0;
  int unsigned hold_requests = 0;

  // --------------------------------------------------------------------------
  // Console model: its own copy of both rings, the history and the flags
  // --------------------------------------------------------------------------
  logic [ByteW-1:0]  rx_ring [RingDepth];
  logic [ByteW-1:0]  tx_ring [RingDepth];
  int unsigned       rx_head = 0, rx_fill = 0;
  int unsigned       tx_head = 0, tx_fill = 0;
  logic [ByteW-1:0]  prev_byte = '0, prev2_byte = '0;
  logic [ByteW-1:0]  line_count = '0;
  logic              tx_irq = 1'b0;

  // Append to the receive ring; drop silently when full
  function automatic void rx_push(logic [ByteW-1:0] b);
    if (rx_fill < RingDepth) begin
      rx_ring[(rx_head + rx_fill) % RingDepth] = b;
      rx_fill++;
    end
  endfunction

  // Append to the transmit ring; report whether there was room
  function automatic bit tx_push(logic [ByteW-1:0] b);
    if (tx_fill >= RingDepth) return 1'b0;
    tx_ring[(tx_head + tx_fill) % RingDepth] = b;
    tx_fill++;
    return 1'b1;
  endfunction

  function automatic console_result_t console_step(console_event_t ev);
    console_result_t r;
    r = '0;
    case (ev.kind)
      KIND_RX_BYTE: begin
        if (ev.data == ChBs || ev.data == ChDel) begin
          // Erase the newest entry and echo backspace, space, backspace
          if (rx_fill != 0) begin
            rx_fill--;
            void'(tx_push(ChBs));
            void'(tx_push(ChSp));
            void'(tx_push(ChBs));
            tx_irq = 1'b1;
          end
        end else if (prev_byte != ChCsi && prev2_byte != ChEsc &&
                     ev.data != ChEsc && ev.data != ChCsi) begin
          if (ev.data == ChLf && line_count != MsgMax) line_count++;
          rx_push(ev.data);
          if (tx_push(ev.data)) begin
            if (ev.data == ChCr) void'(tx_push(ChLf));
            tx_irq = 1'b1;
          end
        end
        // History shifts on every received byte, filtered or not
        prev2_byte = prev_byte;
        prev_byte  = ev.data;
      end
      KIND_TX_READY: begin
        if (tx_fill != 0) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_ring[tx_head];
          tx_head = (tx_head + 1) % RingDepth;
          tx_fill--;
        end else begin
          tx_irq = 1'b0;
        end
      end
      KIND_HOST_READ: begin
        if (rx_fill != 0) begin
          r.host_valid = 1'b1;
          r.host_byte  = rx_ring[rx_head];
          rx_head = (rx_head + 1) % RingDepth;
          rx_fill--;
        end else begin
          r.refused = 1'b1;
        end
      end
      default: begin
        if (tx_push(ev.data)) tx_irq = 1'b1;
        else r.refused = 1'b1;
      end
    endcase
    r.messages        = line_count;
    r.transmit_enable = tx_irq;
    r.receive_level   = LevelW'(rx_fill);
    r.transmit_level  = LevelW'(tx_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event driver: hold the offer until transferred, predict on transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        owed_results.push_back(console_step(pending_events.pop_front()));
      end
      // Only change the offer once the previous one has gone
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_events.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_events[0].data;
          s_axis_tuser_i  <= pending_events[0].kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: random back-pressure, plus a long hold-off on request
  // --------------------------------------------------------------------------
  int unsigned hold_left   = 0;
  int unsigned holds_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= 0;
      holds_taken     <= 0;
    end else if (holds_taken != hold_requests) begin
      holds_taken     <= hold_requests;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest owed result
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing owed: %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("line_valid",      want.line_valid,      m_axis_tdata_o[0]);
        check_field("line_byte",       want.line_byte,       m_axis_tdata_o[8:1]);
        check_field("host_valid",      want.host_valid,      m_axis_tdata_o[9]);
        check_field("host_byte",       want.host_byte,       m_axis_tdata_o[17:10]);
        check_field("refused",         want.refused,         m_axis_tdata_o[18]);
        check_field("messages",        want.messages,        m_axis_tdata_o[26:19]);
        check_field("transmit_enable", want.transmit_enable, m_axis_tdata_o[27]);
        check_field("receive_level",   want.receive_level,   m_axis_tdata_o[34:28]);
        check_field("transmit_level",  want.transmit_level,  m_axis_tdata_o[41:35]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_event(kind_e k, logic [ByteW-1:0] b);
    console_event_t ev;
    ev.kind = k;
    ev.data = b;
    pending_events.push_back(ev);
    queued++;
  endfunction

  // Printable byte that passes the escape filter on its own
  function automatic logic [ByteW-1:0] typed_char();
    logic [ByteW-1:0] c;
    c = ByteW'($urandom_range(8'h7E, 8'h20));
    return (c == ChCsi) ? 8'h61 : c;
  endfunction

  // Mostly well-formed console traffic: typed lines with erasures, escape
  // sequences, line drains and host traffic, with a little noise mixed in
  task automatic queue_session(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    goal = queued + n;
    while (queued < goal) begin
      pick = $urandom_range(19);
      if (pick < 8) begin
        repeat ($urandom_range(12, 1)) begin
          if ($urandom_range(9) == 0) queue_event(KIND_RX_BYTE, $urandom_range(1) ? ChBs : ChDel);
          else queue_event(KIND_RX_BYTE, typed_char());
        end
        case ($urandom_range(2))
          0: queue_event(KIND_RX_BYTE, ChCr);
          1: queue_event(KIND_RX_BYTE, ChLf);
          default: begin
            queue_event(KIND_RX_BYTE, ChCr);
            queue_event(KIND_RX_BYTE, ChLf);
          end
        endcase
      end else if (pick < 10) begin
        queue_event(KIND_RX_BYTE, ChEsc);
        queue_event(KIND_RX_BYTE, ChCsi);
        queue_event(KIND_RX_BYTE, ByteW'($urandom_range(8'h44, 8'h41)));
      end else if (pick < 14) begin
        repeat ($urandom_range(10, 1)) queue_event(KIND_TX_READY, ByteW'($urandom_range(255)));
      end else if (pick < 17) begin
        repeat ($urandom_range(8, 1)) queue_event(KIND_HOST_READ, ByteW'($urandom_range(255)));
      end else if (pick < 18) begin
        repeat ($urandom_range(6, 1)) queue_event(KIND_HOST_WRITE, ByteW'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          queue_event(kind_e'($urandom_range(3)), ByteW'($urandom_range(255)));
        end
      end
    end
  endtask

  // Pause the sender until the block has returned everything owed
  task automatic settle();
    while (pending_events.size() != 0) @(negedge clk_i);
    while (owed_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-ring cases first
    queue_event(KIND_HOST_READ, 8'h00);
    queue_event(KIND_TX_READY, 8'hFF);
    queue_event(KIND_RX_BYTE, ChBs);
    // Byte extremes, an erasure with echo, a carriage return with its line feed
    queue_event(KIND_RX_BYTE, 8'h00);
    queue_event(KIND_RX_BYTE, 8'hFF);
    queue_event(KIND_RX_BYTE, 8'h61);
    queue_event(KIND_RX_BYTE, ChDel);
    queue_event(KIND_RX_BYTE, ChCr);
    queue_event(KIND_RX_BYTE, ChLf);
    // Escape filter: the introducer, the byte after a bracket and the byte
    // two after an escape are all dropped; the byte straight after an escape
    // passes when no bracket follows
    queue_event(KIND_RX_BYTE, ChEsc);
    queue_event(KIND_RX_BYTE, ChCsi);
    queue_event(KIND_RX_BYTE, 8'h41);
    queue_event(KIND_RX_BYTE, ChEsc);
    queue_event(KIND_RX_BYTE, 8'h42);
    queue_event(KIND_RX_BYTE, 8'h43);
    // Host traffic, then drain
    queue_event(KIND_HOST_WRITE, 8'h55);
    queue_event(KIND_HOST_WRITE, 8'hAA);
    repeat (3) queue_event(KIND_TX_READY, 8'h00);
    repeat (2) queue_event(KIND_HOST_READ, 8'hFF);
    settle();

    // Line feed flood under a long result hold-off: both rings fill, the
    // input stalls, and the line count runs into saturation
    repeat (258) queue_event(KIND_RX_BYTE, ChLf);
    hold_requests++;
    // Transmit ring full: host writes refused
    repeat (3) queue_event(KIND_HOST_WRITE, ByteW'($urandom_range(255)));
    // One slot free: the carriage return echoes but its line feed is lost
    queue_event(KIND_TX_READY, 8'h00);
    queue_event(KIND_RX_BYTE, ChCr);
    // Two slots free: the erase echo is cut short
    repeat (2) queue_event(KIND_TX_READY, 8'h00);
    queue_event(KIND_RX_BYTE, ChBs);
    // Drain both rings past empty
    repeat (66) queue_event(KIND_TX_READY, ByteW'($urandom_range(255)));
    repeat (66) queue_event(KIND_HOST_READ, ByteW'($urandom_range(255)));
    settle();

    // Random console sessions: one stretch without idling, then random gaps
    queue_session(60);
    calm = 1'b1;
    while (pending_events.size() != 0) @(negedge clk_i);
    calm = 1'b0;
    queue_session(75);
    settle();

    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("uart_console_line_editor_tb: done, clean");
    end else begin
      $display("uart_console_line_editor_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1200000;
    $display("uart_console_line_editor_tb: done, errors");
    $finish;
  end

endmodule
